### hw/rtl/diatonic_chord_midi_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diatonic chord MIDI generator
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIATONIC_CHORD_MIDI_GENERATOR_TOP_MACROS_SVH
`define DIATONIC_CHORD_MIDI_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define DCMG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dcmg_pkg.sv
// ----------------------------------------------------------------------------
// dcmg_pkg
// Types, codes and scale tables shared by the chord MIDI generator.
// ----------------------------------------------------------------------------
package dcmg_pkg;

  typedef enum logic [3:0] {
    CMD_CHORD     = 4'd0,
    CMD_OCT_UP    = 4'd1,
    CMD_OCT_DOWN  = 4'd2,
    CMD_TRANS_UP  = 4'd3,
    CMD_TRANS_DN  = 4'd4,
    CMD_SEVENTH   = 4'd5,
    CMD_ALTER     = 4'd6,
    CMD_WHEEL_UP  = 4'd7,
    CMD_WHEEL_DN  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    MSG_NOTE_ON  = 2'd0,
    MSG_NOTE_OFF = 2'd1,
    MSG_CTRL     = 2'd2
  } msg_kind_e;

  localparam int unsigned MaxMsgs = 5;
  localparam int unsigned CntW    = 3;
  localparam int unsigned NumDeg  = 7;

  localparam logic [2:0] DimDegree  = 3'd6;
  localparam logic [7:0] OctaveStep = 8'd12;
  localparam logic [6:0] VelOn      = 7'd127;
  localparam logic [6:0] VelOff     = 7'd0;
  localparam logic [6:0] WheelMax   = 7'd127;
  localparam logic [7:0] WheelCtrl  = 8'h01;

  typedef struct packed {
    logic [3:0] cmd;
    logic [2:0] chord_degree;
    logic       pressed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] msg_kind;
    logic [7:0] note_or_control;
    logic [6:0] data_value;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] octave_offset;
    logic [7:0] transpose_offset;
    logic       seventh_held;
    logic       alter_held;
    logic [6:0] wheel_level;
  } state_t;

  typedef struct packed {
    logic [CntW-1:0]            cnt;
    out_item_t [MaxMsgs-1:0]    msg;
  } burst_t;

  function automatic logic [7:0] root_note(logic [2:0] deg);
    logic [7:0] r;
    case (deg)
      3'd0:    r = 8'd60;
      3'd1:    r = 8'd62;
      3'd2:    r = 8'd64;
      3'd3:    r = 8'd65;
      3'd4:    r = 8'd67;
      3'd5:    r = 8'd69;
      3'd6:    r = 8'd71;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // C, F and G are the major chords of the scale.
  function automatic logic is_major(logic [2:0] deg);
    return (deg == 3'd0) || (deg == 3'd3) || (deg == 3'd4);
  endfunction

  // Major seventh on C and F, minor seventh elsewhere.
  function automatic logic [7:0] seventh_step(logic [2:0] deg);
    return ((deg == 3'd0) || (deg == 3'd3)) ? 8'd11 : 8'd10;
  endfunction

endpackage

### hw/rtl/dcmg_burst_gen.sv
// ----------------------------------------------------------------------------
// dcmg_burst_gen
// Decodes one key event against the current state into the next state, the
// chord latch write and the burst of up to five MIDI messages it causes.
// ----------------------------------------------------------------------------
module dcmg_burst_gen (
  input  dcmg_pkg::in_item_t item_i,
  input  dcmg_pkg::state_t   state_i,
  input  logic [7:0]         latch_rd_i,
  output dcmg_pkg::state_t   state_o,
  output logic               latch_we_o,
  output logic [7:0]         latch_wd_o,
  output dcmg_pkg::burst_t   burst_o
);

  logic                       deg_ok;
  logic                       is_dim;
  logic [7:0]                 sum_off;
  logic [7:0]                 lat_off;
  logic [7:0]                 base;
  logic [7:0]                 third;
  logic [7:0]                 sev;
  logic [dcmg_pkg::CntW-1:0]  cnt;
  logic [1:0]                 kind;
  logic [6:0]                 val;
  logic [7:0]                 note [dcmg_pkg::MaxMsgs];

  assign deg_ok  = (item_i.chord_degree <= dcmg_pkg::DimDegree);
  assign is_dim  = (item_i.chord_degree == dcmg_pkg::DimDegree);
  assign sum_off = state_i.octave_offset + state_i.transpose_offset;
  // A press uses the offset it latches; a release uses the stored one.
  assign lat_off = item_i.pressed ? sum_off : latch_rd_i;
  assign base    = dcmg_pkg::root_note(item_i.chord_degree) + lat_off;
  assign third   = (dcmg_pkg::is_major(item_i.chord_degree) ^ state_i.alter_held) ?
                   8'd4 : 8'd3;
  assign sev     = dcmg_pkg::seventh_step(item_i.chord_degree);
  assign latch_wd_o = sum_off;

  always_comb begin
    state_o    = state_i;
    latch_we_o = 1'b0;
    cnt        = '0;
    kind       = dcmg_pkg::MSG_NOTE_ON;
    val        = dcmg_pkg::VelOn;
    for (int i = 0; i < dcmg_pkg::MaxMsgs; i++) begin
      note[i] = base;
    end

    case (dcmg_pkg::cmd_e'(item_i.cmd))
      dcmg_pkg::CMD_CHORD: begin
        if (deg_ok) begin
          if (item_i.pressed) begin
            latch_we_o = 1'b1;
            kind       = dcmg_pkg::MSG_NOTE_ON;
            val        = dcmg_pkg::VelOn;
            note[1]    = is_dim ? base + 8'd3 : base + 8'd7;
            note[2]    = is_dim ? base + 8'd6 : base + third;
            note[3]    = base + sev;
            cnt        = state_i.seventh_held ? 3'd4 : 3'd3;
          end else begin
            kind    = dcmg_pkg::MSG_NOTE_OFF;
            val     = dcmg_pkg::VelOff;
            note[1] = base + 8'd3;
            note[2] = is_dim ? base + 8'd6 : base + 8'd4;
            note[3] = is_dim ? base + sev : base + 8'd7;
            note[4] = base + sev;
            cnt     = is_dim ? 3'd4 : 3'd5;
          end
        end
      end
      dcmg_pkg::CMD_OCT_UP: begin
        if (item_i.pressed) begin
          state_o.octave_offset = state_i.octave_offset + dcmg_pkg::OctaveStep;
        end
      end
      dcmg_pkg::CMD_OCT_DOWN: begin
        if (item_i.pressed) begin
          state_o.octave_offset = state_i.octave_offset - dcmg_pkg::OctaveStep;
        end
      end
      dcmg_pkg::CMD_TRANS_UP: begin
        if (item_i.pressed) begin
          state_o.transpose_offset = state_i.transpose_offset + 8'd1;
        end
      end
      dcmg_pkg::CMD_TRANS_DN: begin
        if (item_i.pressed) begin
          state_o.transpose_offset = state_i.transpose_offset - 8'd1;
        end
      end
      dcmg_pkg::CMD_SEVENTH: begin
        state_o.seventh_held = item_i.pressed;
      end
      dcmg_pkg::CMD_ALTER: begin
        state_o.alter_held = item_i.pressed;
      end
      dcmg_pkg::CMD_WHEEL_UP: begin
        if (item_i.pressed) begin
          if (state_i.wheel_level != dcmg_pkg::WheelMax) begin
            state_o.wheel_level = state_i.wheel_level + 7'd1;
          end
          kind    = dcmg_pkg::MSG_CTRL;
          val     = state_o.wheel_level;
          note[0] = dcmg_pkg::WheelCtrl;
          cnt     = 3'd1;
        end
      end
      dcmg_pkg::CMD_WHEEL_DN: begin
        if (item_i.pressed) begin
          if (state_i.wheel_level != 7'd0) begin
            state_o.wheel_level = state_i.wheel_level - 7'd1;
          end
          kind    = dcmg_pkg::MSG_CTRL;
          val     = state_o.wheel_level;
          note[0] = dcmg_pkg::WheelCtrl;
          cnt     = 3'd1;
        end
      end
      default: begin
      end
    endcase

    burst_o.cnt = cnt;
    for (int i = 0; i < dcmg_pkg::MaxMsgs; i++) begin
      burst_o.msg[i].msg_kind        = kind;
      burst_o.msg[i].note_or_control = note[i];
      burst_o.msg[i].data_value      = val;
      burst_o.msg[i].last            = (dcmg_pkg::CntW'(i) == (cnt - 3'd1));
    end
  end

endmodule

### hw/rtl/diatonic_chord_midi_generator_top.sv
// ----------------------------------------------------------------------------
// diatonic_chord_midi_generator_top
// The first message of an event passes the input register and then the burst
// buffer before it is shown; the buffer loads only when it is free.
// The output sends one message beat per cycle while out_stall_i is low; an
// event that sends no messages only updates state and never waits on the buffer.
// The next key beat is taken while the previous burst is still draining.
// Reset (asynchronous, rst_ni low) clears offsets, modifiers, wheel level,
// all seven chord latches and both pipeline stages at once.
// ----------------------------------------------------------------------------
module diatonic_chord_midi_generator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcmg_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcmg_pkg::out_item_t out_item_o
);

  // Input register: one key event waiting to be decoded.
  logic               in_vld_q, in_vld_d;
  dcmg_pkg::in_item_t in_q;

  // Architectural state. The chord latches are seven flops rows cleared by
  // reset; each is read only at the degree of the decoded event.
  dcmg_pkg::state_t   st_q, st_d;
  logic [7:0]         latch_q [dcmg_pkg::NumDeg];
  logic [7:0]         latch_rd;
  logic               latch_we;
  logic [7:0]         latch_wd;

  // Burst buffer: the messages of one event, shifted out from entry zero.
  dcmg_pkg::burst_t   gen_burst;
  dcmg_pkg::out_item_t msg_q [dcmg_pkg::MaxMsgs];
  logic [dcmg_pkg::CntW-1:0] buf_cnt_q, buf_cnt_d;

  logic pop;
  logic buf_free;
  logic adv;
  logic load;
  logic accept;

  // Degree seven has no latch; its read is forced to zero and never used.
  assign latch_rd = (in_q.chord_degree <= dcmg_pkg::DimDegree) ?
                    latch_q[in_q.chord_degree] : 8'd0;

  dcmg_burst_gen u_gen (
    .item_i     (in_q),
    .state_i    (st_q),
    .latch_rd_i (latch_rd),
    .state_o    (st_d),
    .latch_we_o (latch_we),
    .latch_wd_o (latch_wd),
    .burst_o    (gen_burst)
  );

  // An output beat leaves when shown and not stalled.
  assign out_valid_o = (buf_cnt_q != '0);
  assign out_item_o  = msg_q[0];
  assign pop         = out_valid_o && !out_stall_i;

  // The buffer can take a new burst when empty or when its last beat leaves.
  assign buf_free = (buf_cnt_q == '0) || ((buf_cnt_q == 3'd1) && pop);

  // An event with no messages only updates state, so it never waits on the
  // buffer. State updates happen here, strictly in event order.
  assign adv  = in_vld_q && ((gen_burst.cnt == '0) || buf_free);
  assign load = adv && (gen_burst.cnt != '0);

  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    buf_cnt_d = buf_cnt_q;
    if (load) begin
      buf_cnt_d = gen_burst.cnt;
    end else if (pop) begin
      buf_cnt_d = buf_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      buf_cnt_q <= '0;
      st_q      <= '0;
      for (int i = 0; i < dcmg_pkg::NumDeg; i++) begin
        latch_q[i] <= 8'd0;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      buf_cnt_q <= buf_cnt_d;
      if (adv) begin
        st_q <= st_d;
        if (latch_we) begin
          latch_q[in_q.chord_degree] <= latch_wd;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (load) begin
      for (int i = 0; i < dcmg_pkg::MaxMsgs; i++) begin
        msg_q[i] <= gen_burst.msg[i];
      end
    end else if (pop) begin
      for (int i = 0; i < dcmg_pkg::MaxMsgs - 1; i++) begin
        msg_q[i] <= msg_q[i+1];
      end
    end
  end

  `include "diatonic_chord_midi_generator_top_macros.svh"

  // A stalled beat keeps its place in the burst.
  `DCMG_ASSERT_NEXT(a_hold_cnt, out_valid_o && out_stall_i, $stable(buf_cnt_q), "burst moved while stalled")
  // The last flag marks exactly the final buffered beat.
  `DCMG_ASSERT_NOW(a_last_flag, out_valid_o, out_item_o.last == (buf_cnt_q == 3'd1), "last flag out of step with burst count")
  // The buffer never holds more than one event's burst.
  `DCMG_ASSERT_NOW(a_cnt_max, 1'b1, buf_cnt_q <= 3'd5, "burst count exceeds five")
  // Input stalls only when an event is waiting on a busy buffer.
  `DCMG_ASSERT_NOW(a_stall_cause, in_stall_o, in_vld_q && (buf_cnt_q != '0), "input stalled with nothing pending")

endmodule
